>>> design/lfeba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfeba_pkg
// Shared types, register codes and widths of the epipolar binning block.
// ----------------------------------------------------------------------------
package lfeba_pkg;

  localparam int MAX_COLS_DEF = 512;
  localparam int MAX_ROWS_DEF = 64;
  localparam int CHANNELS     = 3;
  localparam int Q_DEPTH      = 4;

  localparam int BIN_W      = 13;
  localparam int NUM_W      = 32;
  localparam int PROD_W     = NUM_W + BIN_W;
  localparam int VAL_W      = 16;
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 48;
  localparam int DIV_LO_W   = 16;
  localparam int DIV_STEP_W = 5;

  localparam logic [32:0] DISC_LIMIT = 33'd268435456;

  localparam logic [9:0]  RST_COLS   = 10'd300;
  localparam logic [6:0]  RST_ROWS   = 7'd20;
  localparam logic [3:0]  RST_AXIS   = 4'd12;
  localparam logic [31:0] RST_SENSOR = 32'h1000_1000;
  localparam logic [31:0] RST_XY_RNG = 32'h4000_0000;
  localparam logic [31:0] RST_UV_RNG = 32'h4000_C000;

  typedef enum logic [2:0] {
    REG_COLS, REG_ROWS, REG_AXIS, REG_SENSOR,
    REG_X_RNG, REG_Y_RNG, REG_U_RNG, REG_V_RNG
  } cfg_reg_t;

  typedef enum logic {OP_ACC, OP_READ} op_t;

  typedef enum logic [1:0] {COLOR_R, COLOR_G, COLOR_B, COLOR_ALL} color_t;

  typedef struct packed {
    op_t               op;
    logic              keep;
    logic              rd_hit;
    logic [PROD_W-1:0] prod_c;
    logic [NUM_W-1:0]  den_c;
    logic [PROD_W-1:0] prod_r;
    logic [NUM_W-1:0]  den_r;
    logic [BIN_W-1:0]  n_c;
    logic [BIN_W-1:0]  n_r;
    color_t            color;
    logic [VAL_W-1:0]  val_r;
    logic [VAL_W-1:0]  val_g;
    logic [VAL_W-1:0]  val_b;
    logic [8:0]        rd_col;
    logic [5:0]        rd_row;
  } fe_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
  } chan_t;

  typedef enum logic [3:0] {
    BK_CLEAR, BK_IDLE, BK_DIV_COL, BK_DIV_ROW, BK_MEM_RD,
    BK_MEM_UPD, BK_AVG_START, BK_AVG_WAIT, BK_OUT
  } bk_state_t;

endpackage
`default_nettype wire

>>> design/lightfield_epi_binning_average.sv
`default_nettype none
// Accumulate item: the front registers it and queues it; the back end divides out the
// column bin, then the row bin, reads the pixel and writes it back, and takes no new item
// until that write. Read item: the back end reads the pixel, clears it, divides each
// nonempty, unsaturated channel's sum by its count and loads the result register. A rejected
// sample is popped from the queue with no further work. Reset (rst_n low, synchronous) starts a
// clearing pass over MAX_COLS * MAX_ROWS pixels, one per cycle; in_tready stays low until it ends.
// ----------------------------------------------------------------------------
// lightfield_epi_binning_average
// Epipolar-image binning of light-field samples with per-pixel averaging.
// ----------------------------------------------------------------------------
module lightfield_epi_binning_average #(
  parameter int MAX_COLS = lfeba_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lfeba_pkg::MAX_ROWS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lfeba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfeba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // op
  input  wire logic                              in_tuser,
  // pos_x, pos_y, lens_u, lens_v, color, value_r, value_g, value_b, read_col, read_row
  input  wire logic [lfeba_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // avg_r, avg_g, avg_b
  output logic [lfeba_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import lfeba_pkg::*;

  localparam int QCW = $clog2(Q_DEPTH + 1);

  logic           push_valid, pop, q_empty, clearing;
  fe_item_t       push_item, head;
  logic [QCW-1:0] q_count;

  lfeba_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .QDEPTH   (Q_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .hold       (clearing),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  lfeba_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .count     (q_count)
  );

  lfeba_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

>>> design/lfeba_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfeba_div
// Restoring divider, one quotient bit per cycle, shared by binning and average.
// ----------------------------------------------------------------------------
module lfeba_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [lfeba_pkg::NUM_W-1:0]        rem_init,
  input  wire logic [lfeba_pkg::DIV_LO_W-1:0]     low_bits,
  input  wire logic [lfeba_pkg::NUM_W-1:0]        divisor,
  input  wire logic [lfeba_pkg::DIV_STEP_W-1:0]   steps,
  output logic                                    done,
  output logic [lfeba_pkg::DIV_LO_W-1:0]          quot
);
  import lfeba_pkg::*;

  logic                  run_r, done_r;
  logic [DIV_STEP_W-1:0] cnt_r;
  logic [NUM_W-1:0]      rem_r, div_r;
  logic [DIV_LO_W-1:0]   low_r, q_r;
  logic [NUM_W:0]        trial;
  logic                  fits;

  assign trial = {rem_r, low_r[DIV_LO_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == DIV_STEP_W'(1));
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= steps;
      end else if (run_r) begin
        cnt_r <= cnt_r - DIV_STEP_W'(1);
        if (cnt_r == DIV_STEP_W'(1)) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      low_r <= low_bits;
      div_r <= divisor;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= fits ? NUM_W'(trial - {1'b0, div_r}) : NUM_W'(trial);
      low_r <= {low_r[DIV_LO_W-2:0], 1'b0};
      q_r   <= {q_r[DIV_LO_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

>>> design/lfeba_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfeba_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module lfeba_queue #(
  parameter int DEPTH = lfeba_pkg::Q_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire lfeba_pkg::fe_item_t           push_item,
  input  wire logic                          pop,
  output lfeba_pkg::fe_item_t                head,
  output logic                               empty,
  output logic [$clog2(DEPTH+1)-1:0]         count
);
  import lfeba_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  fe_item_t        slot_r [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(DEPTH-1)) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == PW'(DEPTH-1)) ? '0 : rd_r + PW'(1);
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_item;
  end

  assign head  = slot_r[rd_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule
`default_nettype wire

>>> design/lfeba_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfeba_front
// Config registers, range and disc tests, axis selection and bin products.
// ----------------------------------------------------------------------------
module lfeba_front #(
  parameter int MAX_COLS = lfeba_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lfeba_pkg::MAX_ROWS_DEF,
  parameter int QDEPTH   = lfeba_pkg::Q_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lfeba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfeba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic                              in_tuser,
  input  wire logic [lfeba_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                              hold,
  input  wire logic [$clog2(QDEPTH+1)-1:0]       q_count,
  output logic                                   push_valid,
  output lfeba_pkg::fe_item_t                    push_item
);
  import lfeba_pkg::*;

  function automatic logic [BIN_W-1:0] dim_use(input logic [31:0] r, input int mx);
    if (r == 32'd0) return BIN_W'(1);
    if (r > 32'(mx)) return BIN_W'(mx);
    return BIN_W'(r);
  endfunction

  logic [9:0]  cols_r;
  logic [6:0]  rows_r;
  logic [3:0]  axis_r;
  logic [31:0] sensor_r;
  logic [31:0] range_r [4];

  logic signed [16:0] w_ax   [4];
  logic signed [15:0] rng_lo [4];
  logic signed [15:0] rng_hi [4];
  logic signed [33:0] lo_w_r [4];
  logic signed [33:0] hi_w_r [4];
  logic [NUM_W-1:0]   den_r  [4];
  logic [3:0]         rok_r;

  logic [BIN_W-1:0] cols_use, rows_use;

  logic                a_v_r, b_v_r;
  logic                accept;
  op_t                 a_op_r;
  logic [19:0]         a_px_r, a_py_r;
  logic signed [15:0]  a_u_r, a_v_lens_r;
  color_t              a_color_r;
  logic [VAL_W-1:0]    a_vr_r, a_vg_r, a_vb_r;
  logic [8:0]          a_col_r;
  logic [5:0]          a_row_r;

  logic signed [33:0]  ax [4];
  logic [3:0]          hit;
  logic [NUM_W-1:0]    num [4];

  op_t                 b_op_r;
  logic                b_hit_r, b_rd_hit_r;
  logic [31:0]         b_uu_r, b_vv_r;
  logic [NUM_W-1:0]    b_num_c_r, b_num_r_r, b_den_c_r, b_den_r_r;
  logic [BIN_W-1:0]    b_n_c_r, b_n_r_r;
  color_t              b_color_r;
  logic [VAL_W-1:0]    b_vr_r, b_vg_r, b_vb_r;
  logic [8:0]          b_col_r;
  logic [5:0]          b_row_r;
  logic [32:0]         disc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r     <= RST_COLS;
      rows_r     <= RST_ROWS;
      axis_r     <= RST_AXIS;
      sensor_r   <= RST_SENSOR;
      range_r[0] <= RST_XY_RNG;
      range_r[1] <= RST_XY_RNG;
      range_r[2] <= RST_UV_RNG;
      range_r[3] <= RST_UV_RNG;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COLS:   cols_r     <= cfg_wdata[9:0];
        REG_ROWS:   rows_r     <= cfg_wdata[6:0];
        REG_AXIS:   axis_r     <= cfg_wdata[3:0];
        REG_SENSOR: sensor_r   <= cfg_wdata;
        REG_X_RNG:  range_r[0] <= cfg_wdata;
        REG_Y_RNG:  range_r[1] <= cfg_wdata;
        REG_U_RNG:  range_r[2] <= cfg_wdata;
        REG_V_RNG:  range_r[3] <= cfg_wdata;
        default:    cols_r     <= cols_r;
      endcase
    end
  end

  always_comb begin
    w_ax[0] = signed'({1'b0, sensor_r[15:0]});
    w_ax[1] = signed'({1'b0, sensor_r[31:16]});
    w_ax[2] = 17'sd1;
    w_ax[3] = 17'sd1;
    for (int i = 0; i < 4; i++) begin
      rng_lo[i] = signed'(range_r[i][15:0]);
      rng_hi[i] = signed'(range_r[i][31:16]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      lo_w_r[i] <= 34'(rng_lo[i] * w_ax[i]);
      hi_w_r[i] <= 34'(rng_hi[i] * w_ax[i]);
      den_r[i]  <= NUM_W'(w_ax[i] * (17'(rng_hi[i]) - 17'(rng_lo[i])));
      rok_r[i]  <= (w_ax[i] != 17'sd0) && (rng_hi[i] > rng_lo[i]);
    end
  end

  assign cols_use  = dim_use(32'(cols_r), MAX_COLS);
  assign rows_use  = dim_use(32'(rows_r), MAX_ROWS);
  assign in_tready = !hold && (32'(q_count) + 32'(a_v_r) + 32'(b_v_r) < 32'(QDEPTH));
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_op_r     <= op_t'(in_tuser);
      a_px_r     <= in_tdata[19:0];
      a_py_r     <= in_tdata[39:20];
      a_u_r      <= signed'(in_tdata[55:40]);
      a_v_lens_r <= signed'(in_tdata[71:56]);
      a_color_r  <= color_t'(in_tdata[73:72]);
      a_vr_r     <= in_tdata[89:74];
      a_vg_r     <= in_tdata[105:90];
      a_vb_r     <= in_tdata[121:106];
      a_col_r    <= in_tdata[130:122];
      a_row_r    <= in_tdata[136:131];
    end
  end

  always_comb begin
    ax[0] = signed'({4'b0, a_px_r, 10'b0});
    ax[1] = signed'({4'b0, a_py_r, 10'b0});
    ax[2] = 34'(a_u_r);
    ax[3] = 34'(a_v_lens_r);
    for (int i = 0; i < 4; i++) begin
      hit[i] = rok_r[i] && (ax[i] >= lo_w_r[i]) && (ax[i] < hi_w_r[i]);
      num[i] = NUM_W'(ax[i] - lo_w_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    b_op_r     <= a_op_r;
    b_hit_r    <= &hit;
    b_rd_hit_r <= (BIN_W'(a_col_r) < cols_use) && (BIN_W'(a_row_r) < rows_use);
    b_uu_r     <= 32'(a_u_r * a_u_r);
    b_vv_r     <= 32'(a_v_lens_r * a_v_lens_r);
    b_num_c_r  <= num[axis_r[1:0]];
    b_den_c_r  <= den_r[axis_r[1:0]];
    b_num_r_r  <= num[axis_r[3:2]];
    b_den_r_r  <= den_r[axis_r[3:2]];
    b_n_c_r    <= cols_use;
    b_n_r_r    <= rows_use;
    b_color_r  <= a_color_r;
    b_vr_r     <= a_vr_r;
    b_vg_r     <= a_vg_r;
    b_vb_r     <= a_vb_r;
    b_col_r    <= a_col_r;
    b_row_r    <= a_row_r;
  end

  assign disc = {1'b0, b_uu_r} + {1'b0, b_vv_r};

  always_comb begin
    push_item.op     = b_op_r;
    push_item.keep   = b_hit_r && (disc <= DISC_LIMIT);
    push_item.rd_hit = b_rd_hit_r;
    push_item.prod_c = PROD_W'(b_n_c_r * b_num_c_r);
    push_item.den_c  = b_den_c_r;
    push_item.prod_r = PROD_W'(b_n_r_r * b_num_r_r);
    push_item.den_r  = b_den_r_r;
    push_item.n_c    = b_n_c_r;
    push_item.n_r    = b_n_r_r;
    push_item.color  = b_color_r;
    push_item.val_r  = b_vr_r;
    push_item.val_g  = b_vg_r;
    push_item.val_b  = b_vb_r;
    push_item.rd_col = b_col_r;
    push_item.rd_row = b_row_r;
  end

  assign push_valid = b_v_r;

endmodule
`default_nettype wire

>>> design/lfeba_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfeba_back
// Bin division, pixel read-modify-write, averaging and result register.
// ----------------------------------------------------------------------------
module lfeba_back #(
  parameter int MAX_COLS = lfeba_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lfeba_pkg::MAX_ROWS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lfeba_pkg::fe_item_t               head,
  input  wire logic                              q_empty,
  output logic                                   pop,
  output logic                                   clearing,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [lfeba_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import lfeba_pkg::*;

  localparam int PIXELS  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int QB      = $clog2(MAX_DIM + 1);
  localparam int WORD_W  = CHANNELS * (SUM_W + CNT_W);

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [BIN_W-1:0] r,
                                                 input logic [BIN_W-1:0] c);
    return ADDR_W'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  function automatic logic [BIN_W-1:0] clamp_bin(input logic [DIV_LO_W-1:0] q,
                                                 input logic [BIN_W-1:0] n);
    if (32'(q) > 32'(n) - 32'd1) return BIN_W'(32'(n) - 32'd1);
    return BIN_W'(q);
  endfunction

  function automatic chan_t acc_chan(input chan_t w, input logic [VAL_W-1:0] v);
    chan_t          o;
    logic [SUM_W:0] s;
    s = {1'b0, w.sum} + (SUM_W+1)'(v);
    o.sum = s[SUM_W] ? '1 : s[SUM_W-1:0];
    o.cnt = (w.cnt == '1) ? w.cnt : w.cnt + CNT_W'(1);
    return o;
  endfunction

  bk_state_t st_r, st_nxt;

  logic [WORD_W-1:0] mem [PIXELS];
  chan_t             rdata_r [CHANNELS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  chan_t             mem_wdata [CHANNELS];

  logic [ADDR_W-1:0] clr_cnt_r, addr_r;
  fe_item_t          cur_r;
  logic [BIN_W-1:0]  col_r;
  chan_t             word_r [CHANNELS];
  logic [1:0]        ch_r;
  logic [VAL_W-1:0]  avg_r [CHANNELS];
  logic              out_valid_r, out_load;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  div_start, div_done;
  logic [NUM_W-1:0]      div_rem, div_den;
  logic [DIV_LO_W-1:0]   div_lo, div_q;
  logic [DIV_STEP_W-1:0] div_steps;

  chan_t            ch_word;
  logic             ch_zero, ch_sat, ch_last;
  logic [VAL_W-1:0] vals [CHANNELS];

  lfeba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem),
    .low_bits (div_lo),
    .divisor  (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_q)
  );

  assign ch_word = word_r[ch_r];
  assign ch_zero = (ch_word.cnt == '0);
  assign ch_sat  = (ch_word.sum[SUM_W-1:16] >= ch_word.cnt);
  assign ch_last = (ch_r == 2'(CHANNELS-1));
  assign vals[0] = cur_r.val_r;
  assign vals[1] = cur_r.val_g;
  assign vals[2] = cur_r.val_b;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_CLEAR:     if (clr_cnt_r == ADDR_W'(PIXELS-1)) st_nxt = BK_IDLE;
      BK_IDLE: begin
        if (!q_empty) begin
          if (head.op == OP_READ) st_nxt = head.rd_hit ? BK_MEM_RD : BK_OUT;
          else if (head.keep)     st_nxt = BK_DIV_COL;
        end
      end
      BK_DIV_COL:   if (div_done) st_nxt = BK_DIV_ROW;
      BK_DIV_ROW:   if (div_done) st_nxt = BK_MEM_RD;
      BK_MEM_RD:    st_nxt = BK_MEM_UPD;
      BK_MEM_UPD:   st_nxt = (cur_r.op == OP_READ) ? BK_AVG_START : BK_IDLE;
      BK_AVG_START: begin
        if (ch_zero || ch_sat) st_nxt = ch_last ? BK_OUT : BK_AVG_START;
        else                   st_nxt = BK_AVG_WAIT;
      end
      BK_AVG_WAIT:  if (div_done) st_nxt = ch_last ? BK_OUT : BK_AVG_START;
      BK_OUT:       if (!out_valid_r || out_tready) st_nxt = BK_IDLE;
      default:      st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    div_rem   = NUM_W'(head.prod_c >> QB);
    div_lo    = DIV_LO_W'(head.prod_c << (DIV_LO_W - QB));
    div_den   = head.den_c;
    div_steps = DIV_STEP_W'(QB);
    mem_we    = 1'b0;
    mem_addr  = addr_r;
    out_load  = 1'b0;
    for (int c = 0; c < CHANNELS; c++) mem_wdata[c] = '0;
    unique case (st_r)
      BK_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r;
      end
      BK_IDLE: begin
        pop       = !q_empty;
        div_start = !q_empty && (head.op == OP_ACC) && head.keep;
      end
      BK_DIV_COL: begin
        div_start = div_done;
        div_rem   = NUM_W'(cur_r.prod_r >> QB);
        div_lo    = DIV_LO_W'(cur_r.prod_r << (DIV_LO_W - QB));
        div_den   = cur_r.den_r;
      end
      BK_MEM_UPD: begin
        mem_we = 1'b1;
        if (cur_r.op == OP_ACC) begin
          for (int c = 0; c < CHANNELS; c++) begin
            mem_wdata[c] = ((cur_r.color == COLOR_ALL) || (cur_r.color == color_t'(c)))
                           ? acc_chan(rdata_r[c], vals[c]) : rdata_r[c];
          end
        end
      end
      BK_AVG_START: begin
        div_start = !ch_zero && !ch_sat;
        div_rem   = NUM_W'(ch_word.sum[SUM_W-1:16]);
        div_lo    = ch_word.sum[15:0];
        div_den   = NUM_W'(ch_word.cnt);
        div_steps = DIV_STEP_W'(DIV_LO_W);
      end
      BK_OUT:   out_load = !out_valid_r || out_tready;
      default:  pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= {mem_wdata[2], mem_wdata[1], mem_wdata[0]};
    {rdata_r[2], rdata_r[1], rdata_r[0]} <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_CLEAR;
      clr_cnt_r   <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_CLEAR) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (st_r == BK_MEM_UPD) ch_r <= '0;
      else if (((st_r == BK_AVG_START) && (ch_zero || ch_sat)) ||
               ((st_r == BK_AVG_WAIT) && div_done)) begin
        if (!ch_last) ch_r <= ch_r + 2'd1;
      end
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == BK_IDLE) && !q_empty) begin
      cur_r  <= head;
      addr_r <= pix_addr(BIN_W'(head.rd_row), BIN_W'(head.rd_col));
      for (int c = 0; c < CHANNELS; c++) avg_r[c] <= '0;
    end
    if ((st_r == BK_DIV_COL) && div_done) col_r <= clamp_bin(div_q, cur_r.n_c);
    if ((st_r == BK_DIV_ROW) && div_done) addr_r <= pix_addr(clamp_bin(div_q, cur_r.n_r), col_r);
    if (st_r == BK_MEM_UPD) word_r <= rdata_r;
    if (st_r == BK_AVG_START) begin
      if (ch_zero)     avg_r[ch_r] <= '0;
      else if (ch_sat) avg_r[ch_r] <= '1;
    end
    if ((st_r == BK_AVG_WAIT) && div_done) avg_r[ch_r] <= div_q;
    if (out_load) out_data_r <= {avg_r[2], avg_r[1], avg_r[0]};
  end

  assign clearing   = (st_r == BK_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

>>> design/lfeba_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfeba_checker
// Port-level checks of the binning block, bound to the top level.
// ----------------------------------------------------------------------------
module lfeba_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [lfeba_pkg::OUT_DATA_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item dropped or changed while stalled");

  a_clear_no_accept: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("item accepted during memory clear");

  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item shown right after reset");

endmodule

bind lightfield_epi_binning_average lfeba_checker u_chk (.*);
`default_nettype wire

>>> test/lightfield_epi_binning_average_tb.sv
// ----------------------------------------------------------------------------
// lightfield_epi_binning_average_tb
// Streams directed and random samples and pixel reads into the binning block,
// predicts every pixel average from a local image of sums and counts, and
// compares each result item in order. Registers change only while idle.
// ----------------------------------------------------------------------------
module lightfield_epi_binning_average_tb;
  import lfeba_pkg::*;

  localparam int NPIX = MAX_COLS_DEF * MAX_ROWS_DEF * CHANNELS;

  typedef struct packed {
    logic [15:0] b;
    logic [15:0] g;
    logic [15:0] r;
  } avg_t;

  typedef struct {
    op_t         op;
    logic [19:0] px;
    logic [19:0] py;
    logic [15:0] lu;
    logic [15:0] lv;
    color_t      color;
    logic [15:0] vr;
    logic [15:0] vg;
    logic [15:0] vb;
    logic [8:0]  rcol;
    logic [5:0]  rrow;
  } sample_t;

  class binning_scoreboard;
    logic [31:0] regs[8];
    logic [31:0] sums[NPIX];
    logic [15:0] cnts[NPIX];
    avg_t        pending[$];
    int          errors;

    function new();
      regs[REG_COLS]   = RST_COLS;
      regs[REG_ROWS]   = RST_ROWS;
      regs[REG_AXIS]   = RST_AXIS;
      regs[REG_SENSOR] = RST_SENSOR;
      regs[REG_X_RNG]  = RST_XY_RNG;
      regs[REG_Y_RNG]  = RST_XY_RNG;
      regs[REG_U_RNG]  = RST_UV_RNG;
      regs[REG_V_RNG]  = RST_UV_RNG;
      foreach (sums[k]) begin
        sums[k] = 0;
        cnts[k] = 0;
      end
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        REG_COLS: regs[idx] = val & 32'h3FF;
        REG_ROWS: regs[idx] = val & 32'h7F;
        REG_AXIS: regs[idx] = val & 32'hF;
        default:  regs[idx] = val;
      endcase
    endfunction

    function longint dim(logic [31:0] r, int mx);
      if (r == 0) return 1;
      return (r > mx) ? mx : r;
    endfunction

    function bit in_range(longint a, longint w, logic [31:0] rng);
      longint lo, hi;
      lo = longint'($signed(rng[15:0]));
      hi = longint'($signed(rng[31:16]));
      if (w <= 0 || hi <= lo) return 0;
      return a >= lo * w && a < hi * w;
    endfunction

    function longint bin_of(longint a, longint w, logic [31:0] rng, longint n);
      longint lo, hi, idx;
      lo = longint'($signed(rng[15:0]));
      hi = longint'($signed(rng[31:16]));
      idx = (n * (a - lo * w)) / (w * (hi - lo));
      if (idx > n - 1) idx = n - 1;
      if (idx < 0) idx = 0;
      return idx;
    endfunction

    function void bump(int k, logic [15:0] v);
      logic [32:0] s;
      s = sums[k] + v;
      sums[k] = s[32] ? 32'hFFFFFFFF : s[31:0];
      if (cnts[k] != 16'hFFFF) cnts[k] = cnts[k] + 1;
    endfunction

    function void note_input(sample_t s);
      longint cols, rows, a[4], w[4], u, v;
      int col, row, base, k, sel;
      bit ok;
      avg_t res;
      logic [31:0] q;
      cols = dim(regs[REG_COLS], MAX_COLS_DEF);
      rows = dim(regs[REG_ROWS], MAX_ROWS_DEF);
      if (s.op == OP_READ) begin
        res = '0;
        if (s.rcol < cols && s.rrow < rows) begin
          for (int c = 0; c < 3; c++) begin
            k = (s.rrow * MAX_COLS_DEF + s.rcol) * CHANNELS + c;
            q = 0;
            if (cnts[k] != 0) begin
              q = sums[k] / cnts[k];
              if (q > 32'hFFFF) q = 32'hFFFF;
            end
            res[c*16 +: 16] = q[15:0];
            sums[k] = 0;
            cnts[k] = 0;
          end
        end
        pending.push_back(res);
        return;
      end
      u = longint'($signed(s.lu));
      v = longint'($signed(s.lv));
      ok = (u * u + v * v) <= 268435456;
      a[0] = longint'(s.px) * 1024;
      a[1] = longint'(s.py) * 1024;
      a[2] = u;
      a[3] = v;
      w[0] = regs[REG_SENSOR][15:0];
      w[1] = regs[REG_SENSOR][31:16];
      w[2] = 1;
      w[3] = 1;
      for (int i = 0; i < 4; i++)
        if (!in_range(a[i], w[i], regs[REG_X_RNG + i])) ok = 0;
      if (!ok) return;
      sel = regs[REG_AXIS][1:0];
      col = bin_of(a[sel], w[sel], regs[REG_X_RNG + sel], cols);
      sel = regs[REG_AXIS][3:2];
      row = bin_of(a[sel], w[sel], regs[REG_X_RNG + sel], rows);
      base = (row * MAX_COLS_DEF + col) * CHANNELS;
      if (s.color == COLOR_ALL) begin
        bump(base, s.vr);
        bump(base + 1, s.vg);
        bump(base + 2, s.vb);
      end else begin
        bump(base + s.color, s.color == COLOR_R ? s.vr : s.color == COLOR_G ? s.vg : s.vb);
      end
    endfunction

    function void check_result(avg_t got);
      avg_t exp_v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got.r !== exp_v.r) begin
        $display("%0t: avg_r expected %h actual %h", $time, exp_v.r, got.r);
        errors++;
      end
      if (got.g !== exp_v.g) begin
        $display("%0t: avg_g expected %h actual %h", $time, exp_v.g, got.g);
        errors++;
      end
      if (got.b !== exp_v.b) begin
        $display("%0t: avg_b expected %h actual %h", $time, exp_v.b, got.b);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic in_tuser = 0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;

  binning_scoreboard board = new();
  bit sink_hold = 0;
  bit stim_done = 0;

  lightfield_epi_binning_average DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    in_tvalid <= 0;
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    board.set_reg(idx, val);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic send(sample_t s, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    @(negedge clk);
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= s.op;
    in_tdata <= {{(IN_DATA_W - 137){1'b0}}, s.rrow, s.rcol, s.vb, s.vg, s.vr,
                 s.color, s.lv, s.lu, s.py, s.px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(s);
  endtask

  function automatic sample_t rand_sample(bit read_pct);
    sample_t s;
    longint cols, rows, w, h;
    cols = board.dim(board.regs[REG_COLS], MAX_COLS_DEF);
    rows = board.dim(board.regs[REG_ROWS], MAX_ROWS_DEF);
    w = board.regs[REG_SENSOR][15:0];
    h = board.regs[REG_SENSOR][31:16];
    s.op = ($urandom_range(0, 99) < (read_pct ? 30 : 0)) ? OP_READ : OP_ACC;
    if ($urandom_range(0, 9) < 8 && w > 0 && h > 0) begin
      s.px = $urandom_range(0, (w * 16 > 1048575) ? 1048575 : w * 16 - 1);
      s.py = $urandom_range(0, (h * 16 > 1048575) ? 1048575 : h * 16 - 1);
      s.lu = 16'($signed($urandom_range(0, 23000)) - 11500);
      s.lv = 16'($signed($urandom_range(0, 23000)) - 11500);
    end else begin
      s.px = $urandom;
      s.py = $urandom;
      s.lu = $urandom;
      s.lv = $urandom;
    end
    s.color = color_t'($urandom_range(0, 3));
    s.vr = $urandom;
    s.vg = $urandom;
    s.vb = $urandom;
    if ($urandom_range(0, 9) < 8) begin
      s.rcol = $urandom_range(0, cols - 1);
      s.rrow = $urandom_range(0, rows - 1);
    end else begin
      s.rcol = $urandom;
      s.rrow = $urandom;
    end
    return s;
  endfunction

  // Read back every pixel a small image can hold.
  task automatic sweep(int cols, int rows);
    sample_t s;
    s = rand_sample(0);
    s.op = OP_READ;
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++) begin
        s.rcol = c;
        s.rrow = r;
        send(s, 1);
      end
  endtask

  initial begin
    sample_t s;
    repeat (5) @(negedge clk);
    rst_n <= 1;

    // Small image, columns binned on x and rows on lens v, so that pixels collide.
    write_reg(REG_COLS, 4);
    write_reg(REG_ROWS, 3);
    s = rand_sample(0);
    s.op = OP_ACC; s.lu = 16'sd0; s.lv = 16'sd0; s.px = 20'h0; s.py = 20'h0;
    s.color = COLOR_ALL; s.vr = 16'hFFFF; s.vg = 16'h0; s.vb = 16'h1234;
    send(s, 0);
    send(s, 0);
    s.color = COLOR_R; s.vr = 16'h0001; send(s, 0);
    s.color = COLOR_G; s.vg = 16'hFFFF; send(s, 0);
    s.color = COLOR_B; send(s, 0);
    s.lu = 16'h4000; s.lv = 16'h0; s.color = COLOR_ALL; send(s, 0);
    s.lu = 16'hC000; send(s, 0);
    s.lu = 16'h3FFF; s.lv = 16'h0; send(s, 0);
    s.lu = 16'h2D41; s.lv = 16'h2D41; send(s, 0);
    s.lu = 16'h8000; s.lv = 16'h7FFF; send(s, 0);
    s.px = 20'hFFFFF; s.py = 20'hFFFFF; s.lu = 0; s.lv = 0; send(s, 0);
    sweep(4, 3);
    s.op = OP_READ; s.rcol = 9'h1FF; s.rrow = 6'h3F; send(s, 0);
    s.rcol = 4; s.rrow = 0; send(s, 0);
    drain();

    // Accumulate full-scale values into a single pixel, then read it.
    write_reg(REG_COLS, 1);
    write_reg(REG_ROWS, 1);
    for (int i = 0; i < 3; i++) begin
      s = rand_sample(0);
      s.lu = 0; s.lv = 0; s.color = COLOR_ALL; s.px = 0; s.py = 0;
      s.vr = 16'hFFFF; s.vg = 16'hFFFF; s.vb = 16'hFFFF;
      send(s, 0);
    end
    s.op = OP_READ; s.rcol = 0; s.rrow = 0; send(s, 0);
    drain();

    // Random phases across register settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_COLS, 8); write_reg(REG_ROWS, 4); write_reg(REG_AXIS, 4'b0100);
          write_reg(REG_SENSOR, 32'h0010_0020);
        end
        1: begin
          write_reg(REG_AXIS, 4'b1110); write_reg(REG_U_RNG, 32'h2000_E000);
          write_reg(REG_V_RNG, 32'h1000_D000);
        end
        2: begin
          write_reg(REG_COLS, 0); write_reg(REG_ROWS, 0); write_reg(REG_AXIS, 4'b1001);
          write_reg(REG_X_RNG, 32'h4000_1000); write_reg(REG_Y_RNG, 32'h3000_0000);
        end
        3: begin
          write_reg(REG_COLS, 10'h3FF); write_reg(REG_ROWS, 7'h7F);
          write_reg(REG_AXIS, 4'b0011); write_reg(REG_SENSOR, 32'hFFFF_FFFF);
        end
        4: begin
          write_reg(REG_COLS, 6); write_reg(REG_ROWS, 5); write_reg(REG_SENSOR, 32'h0000_0040);
        end
        5: begin
          write_reg(REG_SENSOR, 32'h0008_0008); write_reg(REG_X_RNG, 32'h2000_2000);
        end
        6: begin
          write_reg(REG_X_RNG, 32'h7FFF_8000); write_reg(REG_Y_RNG, 32'h7FFF_8000);
          write_reg(REG_U_RNG, 32'h7FFF_8000); write_reg(REG_V_RNG, 32'h7FFF_8000);
          write_reg(REG_AXIS, 4'b0110);
        end
        default: begin
          write_reg(REG_COLS, 512); write_reg(REG_ROWS, 64); write_reg(REG_AXIS, 4'b1100);
          write_reg(REG_U_RNG, 32'h4000_C000);
        end
      endcase
      if (ph == 3) begin
        sink_hold = 1;
        for (int i = 0; i < 8; i++) begin
          s = rand_sample(0);
          s.op = OP_READ;
          send(s, 0);
        end
        sink_hold = 0;
      end
      for (int i = 0; i < 70; i++) send(rand_sample(1), 1);
      if (ph == 1) drain();
      drain();
    end
    stim_done = 1;
  end

  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        out_tready <= 0;
        repeat (400) @(negedge clk);
        out_tready <= 1;
        wait (!sink_hold);
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_tready <= 0;
          repeat (g - 1) @(negedge clk);
        end else begin
          out_tready <= 1;
        end
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) board.check_result(avg_t'(out_tdata));

  initial begin
    wait (stim_done);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
